FILE: rtl/core/tle_pkg.sv
// Package for the terminal line editor: widths, key and action codes,
// and the sequencer state type. No dependencies.
package tle_pkg;

	localparam int LINE_CAPACITY_DEF = 40;
	localparam int LEN_W  = 6;
	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int ACT_W  = 3;

	localparam logic [ACT_W-1:0] ACT_ECHO    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ERASE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_NL_ECHO = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REDRAW  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_BELL    = 3'd5;
	localparam logic [ACT_W-1:0] ACT_END     = 3'd6;

	localparam logic [BYTE_W-1:0] KEY_ERASE = 8'd127;
	localparam logic [BYTE_W-1:0] KEY_KILL  = 8'd21;
	localparam logic [BYTE_W-1:0] KEY_WORD  = 8'd23;
	localparam logic [BYTE_W-1:0] KEY_EOF   = 8'd4;
	localparam logic [BYTE_W-1:0] PRINT_LO  = 8'd32;
	localparam logic [BYTE_W-1:0] PRINT_HI  = 8'd126;
	localparam logic [CHAR_W-1:0] SPACE_CH  = 7'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_W_RD,
		ST_W_CHK,
		ST_CLEAR,
		ST_R_RD,
		ST_R_EMIT
	} state_t;

	// one terminal action offered to the output register
	typedef struct packed {
		logic              valid;
		logic [ACT_W-1:0]  action;
		logic [CHAR_W-1:0] ch;
		logic [LEN_W-1:0]  count;
		logic              last;
	} emit_t;

endpackage

FILE: rtl/core/terminal_line_editor_top.sv
// A single-action byte passes through the ST_SINGLE state and then the out_valid
// register; the next byte is taken only once the sequencer is back in ST_IDLE.
// Word erase: ST_W_RD and ST_W_CHK per scanned character, ST_R_RD and ST_R_EMIT per
// redrawn character, set by the single registered read port of the line store.
// After reset the line is empty and not ended; store contents are left as is.
// Top level of the terminal line editor; depends on tle_pkg and tle_ctrl.
module terminal_line_editor_top #(
	parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tle_pkg::BYTE_W-1:0] in_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tle_pkg::ACT_W-1:0]  action,
	output logic [tle_pkg::CHAR_W-1:0] out_char,
	output logic [tle_pkg::LEN_W-1:0]  erase_count,
	output logic                       last
);

	tle_pkg::emit_t emit;
	logic           out_free;

	assign out_free = !out_valid || out_ready;

	tle_ctrl #(.LINE_CAPACITY(LINE_CAPACITY)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.out_free (out_free),
		.emit     (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			action      <= emit.action;
			out_char    <= emit.ch;
			erase_count <= emit.count;
			last        <= emit.last;
		end
	end

endmodule

FILE: rtl/core/tle_store.sv
// Line store: single write port, single registered read port.
// Depends on tle_pkg.
module tle_store #(
	parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF,
	localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [tle_pkg::CHAR_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [tle_pkg::CHAR_W-1:0] rdata
);

	logic [tle_pkg::CHAR_W-1:0] mem_q [LINE_CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/tle_ctrl.sv
// Sequencer for the line editor: decodes each byte, walks the line store
// for word erase (pos_q decrement) and redraw (pos_q increment and end compare).
// Depends on tle_pkg and tle_store.
module tle_ctrl #(
	parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tle_pkg::BYTE_W-1:0] in_byte,
	input  logic                       out_free,
	output tle_pkg::emit_t             emit
);

	localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
	localparam logic [tle_pkg::LEN_W-1:0] CAP = tle_pkg::LEN_W'(LINE_CAPACITY);
	localparam logic [tle_pkg::LEN_W-1:0] ONE = tle_pkg::LEN_W'(1);

	tle_pkg::state_t state_q, state_d;

	logic [tle_pkg::LEN_W-1:0]  len_q, pos_q;
	logic                       word_ph_q, ended_q;
	logic [tle_pkg::ACT_W-1:0]  pend_act_q;
	logic [tle_pkg::CHAR_W-1:0] pend_ch_q;
	logic [tle_pkg::LEN_W-1:0]  pend_cnt_q;

	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [tle_pkg::CHAR_W-1:0] mem_rdata;

	logic                       accept, is_print, has_room, rd_space, at_end;
	logic [tle_pkg::LEN_W-1:0]  pos_dec, pos_inc;

	assign accept   = in_valid && in_ready;
	assign is_print = in_byte inside {[tle_pkg::PRINT_LO:tle_pkg::PRINT_HI]};
	assign has_room = len_q < CAP;
	assign rd_space = mem_rdata == tle_pkg::SPACE_CH;
	// shared step unit
	assign pos_dec  = pos_q - ONE;
	assign pos_inc  = pos_q + ONE;
	assign at_end   = pos_inc == len_q;

	tle_store #(.LINE_CAPACITY(LINE_CAPACITY)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (in_byte[tle_pkg::CHAR_W-1:0]),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tle_pkg::ST_IDLE: begin
				if (accept && !ended_q) begin
					if (in_byte == tle_pkg::KEY_WORD && !(in_byte == tle_pkg::KEY_EOF))
						state_d = tle_pkg::ST_W_RD;
					else
						state_d = tle_pkg::ST_SINGLE;
				end
			end
			tle_pkg::ST_SINGLE: begin
				if (out_free) state_d = tle_pkg::ST_IDLE;
			end
			tle_pkg::ST_W_RD: begin
				if (pos_q == '0) state_d = tle_pkg::ST_CLEAR;
				else state_d = tle_pkg::ST_W_CHK;
			end
			tle_pkg::ST_W_CHK: begin
				if (word_ph_q && rd_space) state_d = tle_pkg::ST_CLEAR;
				else state_d = tle_pkg::ST_W_RD;
			end
			tle_pkg::ST_CLEAR: begin
				if (out_free) begin
					if (pos_q == '0) state_d = tle_pkg::ST_IDLE;
					else state_d = tle_pkg::ST_R_RD;
				end
			end
			tle_pkg::ST_R_RD: begin
				state_d = tle_pkg::ST_R_EMIT;
			end
			tle_pkg::ST_R_EMIT: begin
				if (out_free) begin
					if (at_end) state_d = tle_pkg::ST_IDLE;
					else state_d = tle_pkg::ST_R_RD;
				end
			end
			default: state_d = tle_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = has_room ? len_q[AW-1:0] : '0;
		mem_re    = 1'b0;
		mem_raddr = pos_q[AW-1:0];
		emit      = '0;
		case (state_q)
			tle_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				mem_we   = accept && !ended_q && is_print;
			end
			tle_pkg::ST_SINGLE: begin
				emit.valid  = 1'b1;
				emit.action = pend_act_q;
				emit.ch     = pend_ch_q;
				emit.count  = pend_cnt_q;
				emit.last   = 1'b1;
			end
			tle_pkg::ST_W_RD: begin
				mem_re    = pos_q != '0;
				mem_raddr = pos_dec[AW-1:0];
			end
			tle_pkg::ST_CLEAR: begin
				emit.valid  = 1'b1;
				emit.action = tle_pkg::ACT_CLEAR;
				emit.last   = pos_q == '0;
			end
			tle_pkg::ST_R_RD: begin
				mem_re = 1'b1;
			end
			tle_pkg::ST_R_EMIT: begin
				emit.valid  = 1'b1;
				emit.action = tle_pkg::ACT_REDRAW;
				emit.ch     = mem_rdata;
				emit.last   = at_end;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tle_pkg::ST_IDLE;
			len_q     <= '0;
			pos_q     <= '0;
			word_ph_q <= 1'b0;
			ended_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tle_pkg::ST_IDLE: begin
					if (accept && !ended_q) begin
						if (in_byte == tle_pkg::KEY_EOF && len_q == '0) begin
							ended_q <= 1'b1;
						end else if (in_byte == tle_pkg::KEY_ERASE) begin
							if (len_q != '0) len_q <= len_q - ONE;
						end else if (in_byte == tle_pkg::KEY_KILL) begin
							len_q <= '0;
						end else if (in_byte == tle_pkg::KEY_WORD) begin
							pos_q     <= len_q;
							word_ph_q <= 1'b0;
						end else if (is_print) begin
							len_q <= has_room ? len_q + ONE : ONE;
						end
					end
				end
				tle_pkg::ST_W_CHK: begin
					if (!word_ph_q) begin
						pos_q <= pos_dec;
						if (!rd_space) word_ph_q <= 1'b1;
					end else if (!rd_space) begin
						pos_q <= pos_dec;
					end
				end
				tle_pkg::ST_CLEAR: begin
					len_q <= pos_q;
					if (out_free) pos_q <= '0;
				end
				tle_pkg::ST_R_EMIT: begin
					if (out_free) pos_q <= pos_inc;
				end
				default: ;
			endcase
		end
	end

	// single-result payload, captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_ch_q  <= '0;
			pend_cnt_q <= '0;
			if (in_byte == tle_pkg::KEY_EOF && len_q == '0) begin
				pend_act_q <= tle_pkg::ACT_END;
			end else if (in_byte == tle_pkg::KEY_ERASE) begin
				pend_act_q <= tle_pkg::ACT_ERASE;
				pend_cnt_q <= (len_q != '0) ? ONE : '0;
			end else if (in_byte == tle_pkg::KEY_KILL) begin
				pend_act_q <= tle_pkg::ACT_ERASE;
				pend_cnt_q <= len_q;
			end else if (is_print) begin
				pend_act_q <= has_room ? tle_pkg::ACT_ECHO : tle_pkg::ACT_NL_ECHO;
				pend_ch_q  <= in_byte[tle_pkg::CHAR_W-1:0];
			end else begin
				pend_act_q <= tle_pkg::ACT_BELL;
			end
		end
	end

endmodule

FILE: sim/tb_terminal_line_editor_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for terminal_line_editor_top: keyboard bytes in, terminal actions out.
// Depends on tle_pkg and the RTL of the block; holds its own line-editing predictor.
module tb_terminal_line_editor_top;

	localparam int CAP = tle_pkg::LINE_CAPACITY_DEF;

	typedef struct packed {
		logic [tle_pkg::ACT_W-1:0]  action;
		logic [tle_pkg::CHAR_W-1:0] ch;
		logic [tle_pkg::LEN_W-1:0]  count;
		logic                       last;
	} term_action_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [tle_pkg::BYTE_W-1:0] in_byte = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [tle_pkg::ACT_W-1:0]  action;
	logic [tle_pkg::CHAR_W-1:0] out_char;
	logic [tle_pkg::LEN_W-1:0]  erase_count;
	logic                       last;

	logic [tle_pkg::BYTE_W-1:0] pending_bytes[$];
	term_action_t               expected_actions[$];
	term_action_t               want;

	// predictor state
	logic [tle_pkg::CHAR_W-1:0] line_chars[CAP];
	int                         line_len = 0;
	bit                         line_done = 1'b0;

	int errors = 0;
	int burst_left = 1;
	int gap_left = 0;
	int cyc_count = 0;

	terminal_line_editor_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.out_char(out_char),
		.erase_count(erase_count),
		.last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void push_result(input logic [tle_pkg::ACT_W-1:0] act,
			input logic [tle_pkg::CHAR_W-1:0] ch,
			input logic [tle_pkg::LEN_W-1:0] cnt, input logic lst);
		term_action_t r;
		r.action = act;
		r.ch     = ch;
		r.count  = cnt;
		r.last   = lst;
		expected_actions.push_back(r);
	endfunction

	task automatic predict_line_edit(input logic [tle_pkg::BYTE_W-1:0] b);
		int keep;
		int i;
		if (line_done) begin
			// input after end of file is dropped without any action
		end else if (b == tle_pkg::KEY_EOF && line_len == 0) begin
			line_done = 1'b1;
			push_result(tle_pkg::ACT_END, '0, '0, 1'b1);
		end else if (b == tle_pkg::KEY_ERASE) begin
			push_result(tle_pkg::ACT_ERASE, '0,
				(line_len > 0) ? tle_pkg::LEN_W'(1) : tle_pkg::LEN_W'(0), 1'b1);
			if (line_len > 0)
				line_len--;
		end else if (b == tle_pkg::KEY_KILL) begin
			push_result(tle_pkg::ACT_ERASE, '0, tle_pkg::LEN_W'(line_len), 1'b1);
			line_len = 0;
		end else if (b == tle_pkg::KEY_WORD) begin
			keep = line_len;
			while (keep > 0 && line_chars[keep-1] == tle_pkg::SPACE_CH)
				keep--;
			while (keep > 0 && line_chars[keep-1] != tle_pkg::SPACE_CH)
				keep--;
			push_result(tle_pkg::ACT_CLEAR, '0, '0, keep == 0);
			for (i = 0; i < keep; i++)
				push_result(tle_pkg::ACT_REDRAW, line_chars[i], '0, i == keep - 1);
			line_len = keep;
		end else if (b >= tle_pkg::PRINT_LO && b <= tle_pkg::PRINT_HI) begin
			if (line_len < CAP) begin
				line_chars[line_len] = b[tle_pkg::CHAR_W-1:0];
				line_len++;
				push_result(tle_pkg::ACT_ECHO, b[tle_pkg::CHAR_W-1:0], '0, 1'b1);
			end else begin
				line_chars[0] = b[tle_pkg::CHAR_W-1:0];
				line_len = 1;
				push_result(tle_pkg::ACT_NL_ECHO, b[tle_pkg::CHAR_W-1:0], '0, 1'b1);
			end
		end else begin
			push_result(tle_pkg::ACT_BELL, '0, '0, 1'b1);
		end
	endtask

	function automatic logic [tle_pkg::BYTE_W-1:0] rand_print(input bit allow_space);
		return allow_space ? tle_pkg::BYTE_W'($urandom_range(32, 126)) :
			tle_pkg::BYTE_W'($urandom_range(33, 126));
	endfunction

	// clear the line, type it full, then finish with the given key
	task automatic push_line_fill(input int space_pct, input logic [tle_pkg::BYTE_W-1:0] tail);
		int i;
		pending_bytes.push_back(tle_pkg::KEY_KILL);
		for (i = 0; i < CAP; i++)
			pending_bytes.push_back(($urandom_range(0, 99) < space_pct) ?
				tle_pkg::BYTE_W'(tle_pkg::SPACE_CH) : rand_print(1'b0));
		pending_bytes.push_back(tail);
	endtask

	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
			errors++;
		end
	endtask

	// sender: bursts with random gaps; payload held until the transaction completes
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_line_edit(in_byte);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_valid <= 1'b1;
					in_byte  <= pending_bytes.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern steps through four modes as cyc_count advances
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cyc_count++;
			if (out_valid && out_ready) begin
				if (expected_actions.size() == 0) begin
					$display("%0t: unexpected result, action %0d char %0d count %0d last %0d",
						$time, action, out_char, erase_count, last);
					errors++;
				end else begin
					want = expected_actions.pop_front();
					check_field("action", int'(want.action), int'(action));
					check_field("out_char", int'(want.ch), int'(out_char));
					check_field("erase_count", int'(want.count), int'(erase_count));
					check_field("last", int'(want.last), int'(last));
				end
			end
			case ((cyc_count >> 9) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				2: out_ready <= (cyc_count % 3 == 0);
				default: out_ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	initial begin
		int pick;
		int n;
		int i;
		logic [tle_pkg::BYTE_W-1:0] b;

		// empty-line corner cases, bell bytes across the byte range
		pending_bytes.push_back(tle_pkg::KEY_ERASE);
		pending_bytes.push_back(tle_pkg::KEY_KILL);
		pending_bytes.push_back(tle_pkg::KEY_WORD);
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'h80);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(8'h1F);
		pending_bytes.push_back(8'h01);
		// printable extremes, Ctrl-D on a non-empty line, word erase over trailing spaces
		pending_bytes.push_back(tle_pkg::PRINT_LO);
		pending_bytes.push_back(tle_pkg::PRINT_HI);
		pending_bytes.push_back(8'h41);
		pending_bytes.push_back(8'h42);
		pending_bytes.push_back(tle_pkg::PRINT_LO);
		pending_bytes.push_back(tle_pkg::PRINT_LO);
		pending_bytes.push_back(tle_pkg::KEY_EOF);
		pending_bytes.push_back(tle_pkg::KEY_WORD);
		pending_bytes.push_back(tle_pkg::KEY_ERASE);
		pending_bytes.push_back(tle_pkg::KEY_ERASE);
		pending_bytes.push_back(tle_pkg::KEY_ERASE);
		pending_bytes.push_back(tle_pkg::KEY_KILL);

		// full line: kill with the widest count, word erase with long redraw
		push_line_fill(0, tle_pkg::KEY_KILL);
		push_line_fill(30, tle_pkg::KEY_WORD);

		while (pending_bytes.size() < 212) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++)
					pending_bytes.push_back(rand_print(1'b0));
				n = $urandom_range(0, 2);
				for (i = 0; i < n; i++)
					pending_bytes.push_back(tle_pkg::BYTE_W'(tle_pkg::SPACE_CH));
			end else if (pick < 53) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					pending_bytes.push_back(tle_pkg::KEY_ERASE);
			end else if (pick < 60) begin
				pending_bytes.push_back(tle_pkg::KEY_WORD);
			end else if (pick < 64) begin
				pending_bytes.push_back(tle_pkg::KEY_KILL);
			end else if (pick < 67) begin
				case ($urandom_range(0, 2))
					0: push_line_fill($urandom_range(0, 40), tle_pkg::KEY_KILL);
					1: push_line_fill($urandom_range(0, 40), tle_pkg::KEY_WORD);
					default: push_line_fill($urandom_range(0, 40), rand_print(1'b1));
				endcase
			end else if (pick < 80) begin
				b = tle_pkg::BYTE_W'($urandom_range(0, 255));
				// keep end of file out of the random part
				if (b == tle_pkg::KEY_EOF)
					b = 8'hC4;
				pending_bytes.push_back(b);
			end else if (pick < 86) begin
				pending_bytes.push_back(rand_print(1'b1));
				pending_bytes.push_back(tle_pkg::KEY_EOF);
			end else begin
				pending_bytes.push_back(rand_print(1'b1));
			end
		end

		// end of input, then bytes that must be dropped
		pending_bytes.push_back(tle_pkg::KEY_KILL);
		pending_bytes.push_back(tle_pkg::KEY_EOF);
		pending_bytes.push_back(8'h78);
		pending_bytes.push_back(tle_pkg::KEY_ERASE);
		pending_bytes.push_back(tle_pkg::KEY_WORD);
		pending_bytes.push_back(tle_pkg::KEY_EOF);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_actions.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
